### src/tpag_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tensor permute address generator package
// Shared widths, register map and reset values.
// ----------------------------------------------------------------------------
package tpag_pkg;

  localparam int unsigned NUM_AXES   = 4;
  localparam int unsigned AXIS_SEL_W = 2;
  localparam int unsigned EXTENT_W   = 7;
  localparam int unsigned ORDER_W    = 8;
  localparam int unsigned OFFSET_W   = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [EXTENT_W-1:0] EXTENT_RESET     = 7'd1;
  // Identity on axis 0, then axes 2, 3, 1.
  localparam logic [ORDER_W-1:0]  AXIS_ORDER_RESET = 8'd120;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXTENT_0   = 3'd0,
    REG_EXTENT_1   = 3'd1,
    REG_EXTENT_2   = 3'd2,
    REG_EXTENT_3   = 3'd3,
    REG_AXIS_ORDER = 3'd4
  } cfg_reg_e;

endpackage
`default_nettype wire

### src/tpag_odometer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Coordinate odometer
// Holds the four coordinates, presents the current element and steps the
// walk by one element per transaction, innermost axis fastest.
// ----------------------------------------------------------------------------
module tpag_odometer
  import tpag_pkg::*;
#(
  parameter int unsigned CW = 6,
  parameter int unsigned EW = 7
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             step_i,
  input  wire logic                             restart_i,
  input  wire logic [NUM_AXES-1:0][EW-1:0]      ext_i,
  output logic      [NUM_AXES-1:0][CW-1:0]      pos_o,
  output logic                                  last_o
);

  logic [NUM_AXES-1:0][CW-1:0] coord_q, coord_d;
  logic [NUM_AXES-1:0][CW-1:0] next_pos;
  logic                        carry;

  // Clear on restart, then ripple the carry from the innermost digit
  always_comb begin
    logic [EW:0] inc;
    pos_o    = restart_i ? '0 : coord_q;
    next_pos = pos_o;
    carry    = 1'b1;
    inc      = '0;
    for (int i = NUM_AXES - 1; i >= 0; i--) begin
      inc = (EW + 1)'(pos_o[i]) + (EW + 1)'(1);
      if (carry) begin
        if (inc < (EW + 1)'(ext_i[i])) begin
          next_pos[i] = CW'(inc);
          carry       = 1'b0;
        end else begin
          next_pos[i] = '0;
        end
      end
    end
    last_o  = carry;
    coord_d = step_i ? next_pos : coord_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_q <= '0;
    end else begin
      coord_q <= coord_d;
    end
  end

endmodule
`default_nettype wire

### src/tpag_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Offset cell
// One Horner step of the row-major offset for source and destination:
// acc = acc * extent + coordinate, registered, with a valid/ready stage.
// ----------------------------------------------------------------------------
module tpag_cell
  import tpag_pkg::*;
#(
  parameter int unsigned CW  = 6,
  parameter int unsigned EW  = 7,
  parameter int unsigned IDX = 0
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [OFFSET_W-1:0]            src_acc_i,
  input  wire logic [OFFSET_W-1:0]            dst_acc_i,
  input  wire logic [NUM_AXES-1:0][CW-1:0]    src_pos_i,
  input  wire logic [NUM_AXES-1:0][CW-1:0]    dst_pos_i,
  input  wire logic                           last_i,
  input  wire logic [EW-1:0]                  src_ext_i,
  input  wire logic [EW-1:0]                  dst_ext_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [OFFSET_W-1:0]            src_acc_o,
  output logic      [OFFSET_W-1:0]            dst_acc_o,
  output logic      [NUM_AXES-1:0][CW-1:0]    src_pos_o,
  output logic      [NUM_AXES-1:0][CW-1:0]    dst_pos_o,
  output logic                                last_o
);

  logic                          valid_q;
  logic [OFFSET_W-1:0]           src_acc_q, src_acc_d;
  logic [OFFSET_W-1:0]           dst_acc_q, dst_acc_d;
  logic [NUM_AXES-1:0][CW-1:0]   src_pos_q, dst_pos_q;
  logic                          last_q;
  logic [OFFSET_W+EW-1:0]        src_prod, dst_prod;
  logic                          load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  // Scale by this axis's extent and add this axis's coordinate
  assign src_prod  = (OFFSET_W + EW)'(src_acc_i) * (OFFSET_W + EW)'(src_ext_i);
  assign dst_prod  = (OFFSET_W + EW)'(dst_acc_i) * (OFFSET_W + EW)'(dst_ext_i);
  assign src_acc_d = src_prod[OFFSET_W-1:0] + OFFSET_W'(src_pos_i[IDX]);
  assign dst_acc_d = dst_prod[OFFSET_W-1:0] + OFFSET_W'(dst_pos_i[IDX]);

  // Hold valid while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Capture payload on each transaction
  always_ff @(posedge clk_i) begin
    if (load) begin
      src_acc_q <= src_acc_d;
      dst_acc_q <= dst_acc_d;
      src_pos_q <= src_pos_i;
      dst_pos_q <= dst_pos_i;
      last_q    <= last_i;
    end
  end

  assign out_valid_o = valid_q;
  assign src_acc_o   = src_acc_q;
  assign dst_acc_o   = dst_acc_q;
  assign src_pos_o   = src_pos_q;
  assign dst_pos_o   = dst_pos_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire

### src/tensor_permute_address_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tensor permute address generator
// Source and destination offsets for a rank-4 row-major axis permutation.
// ----------------------------------------------------------------------------
// Each request transaction returns one address pair: the source offset of the
// current element, its offset in the permuted tensor, and tlast on the final
// element of the walk, after which the walk wraps to the origin. A request
// with restart set starts from the origin. One request is taken every cycle
// while the chain is not stalled; each result passes through the chain of
// four registered multiply-add cells (one per axis). Back-pressure on
// the result side stalls the chain; empty cells still take new requests.
// Registers may be written only while no request is in flight.
// ----------------------------------------------------------------------------
module tensor_permute_address_generator
  import tpag_pkg::*;
#(
  parameter int unsigned MAX_EXTENT = 64
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration write channel
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  // request stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [7:0]             s_axis_tdata,  // [0] restart, [7:1] zero
  // address pair stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [2*OFFSET_W-1:0]       m_axis_tdata,  // [23:0] source_offset,
                                                     // [47:24] dest_offset
  output logic                        m_axis_tlast
);

  localparam int unsigned CW    = $clog2(MAX_EXTENT);
  localparam int unsigned EW    = $clog2(MAX_EXTENT + 1);
  localparam int unsigned CMP_W = (EW > EXTENT_W) ? EW : EXTENT_W;

  logic [NUM_AXES-1:0][EXTENT_W-1:0] extent_q;
  logic [ORDER_W-1:0]                order_q;
  logic [NUM_AXES-1:0][EW-1:0]       src_ext, dst_ext;
  logic [NUM_AXES-1:0][CW-1:0]       cur_pos, cur_dst_pos;
  logic                              cur_last;
  logic                              accept;

  // Cell chain links, index 0 is the request side
  logic                              chain_valid [NUM_AXES+1];
  logic                              chain_ready [NUM_AXES+1];
  logic [OFFSET_W-1:0]               chain_src   [NUM_AXES+1];
  logic [OFFSET_W-1:0]               chain_dst   [NUM_AXES+1];
  logic                              chain_last  [NUM_AXES+1];
  logic [NUM_AXES-1:0][CW-1:0]       chain_spos  [NUM_AXES];
  logic [NUM_AXES-1:0][CW-1:0]       chain_dpos  [NUM_AXES];

  // Configuration registers, unknown indexes dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extent_q <= {NUM_AXES{EXTENT_RESET}};
      order_q  <= AXIS_ORDER_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_EXTENT_0:   extent_q[0] <= cfg_data_i[EXTENT_W-1:0];
        REG_EXTENT_1:   extent_q[1] <= cfg_data_i[EXTENT_W-1:0];
        REG_EXTENT_2:   extent_q[2] <= cfg_data_i[EXTENT_W-1:0];
        REG_EXTENT_3:   extent_q[3] <= cfg_data_i[EXTENT_W-1:0];
        REG_AXIS_ORDER: order_q     <= cfg_data_i[ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp extents to 1..MAX_EXTENT and permute for the destination
  always_comb begin
    logic [CMP_W-1:0]      raw;
    logic [AXIS_SEL_W-1:0] sel;
    raw = '0;
    sel = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      raw = CMP_W'(extent_q[i]);
      if (raw == '0) begin
        src_ext[i] = EW'(1);
      end else if (raw > CMP_W'(MAX_EXTENT)) begin
        src_ext[i] = EW'(MAX_EXTENT);
      end else begin
        src_ext[i] = EW'(raw);
      end
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      sel            = order_q[AXIS_SEL_W*i +: AXIS_SEL_W];
      dst_ext[i]     = src_ext[sel];
      cur_dst_pos[i] = cur_pos[sel];
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  tpag_odometer #(
    .CW (CW),
    .EW (EW)
  ) u_odometer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (accept),
    .restart_i (s_axis_tdata[0]),
    .ext_i     (src_ext),
    .pos_o     (cur_pos),
    .last_o    (cur_last)
  );

  // Feed the chain from the request side
  assign chain_valid[0] = s_axis_tvalid;
  assign s_axis_tready  = chain_ready[0];
  assign chain_src[0]   = '0;
  assign chain_dst[0]   = '0;
  assign chain_last[0]  = cur_last;
  assign chain_spos[0]  = cur_pos;
  assign chain_dpos[0]  = cur_dst_pos;

  // One offset cell per axis, outermost first
  for (genvar k = 0; k < NUM_AXES; k++) begin : g_cell
    if (k < NUM_AXES - 1) begin : g_mid
      tpag_cell #(
        .CW  (CW),
        .EW  (EW),
        .IDX (k)
      ) u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .in_valid_i  (chain_valid[k]),
        .in_ready_o  (chain_ready[k]),
        .src_acc_i   (chain_src[k]),
        .dst_acc_i   (chain_dst[k]),
        .src_pos_i   (chain_spos[k]),
        .dst_pos_i   (chain_dpos[k]),
        .last_i      (chain_last[k]),
        .src_ext_i   (src_ext[k]),
        .dst_ext_i   (dst_ext[k]),
        .out_valid_o (chain_valid[k+1]),
        .out_ready_i (chain_ready[k+1]),
        .src_acc_o   (chain_src[k+1]),
        .dst_acc_o   (chain_dst[k+1]),
        .src_pos_o   (chain_spos[k+1]),
        .dst_pos_o   (chain_dpos[k+1]),
        .last_o      (chain_last[k+1])
      );
    end else begin : g_end
      tpag_cell #(
        .CW  (CW),
        .EW  (EW),
        .IDX (k)
      ) u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .in_valid_i  (chain_valid[k]),
        .in_ready_o  (chain_ready[k]),
        .src_acc_i   (chain_src[k]),
        .dst_acc_i   (chain_dst[k]),
        .src_pos_i   (chain_spos[k]),
        .dst_pos_i   (chain_dpos[k]),
        .last_i      (chain_last[k]),
        .src_ext_i   (src_ext[k]),
        .dst_ext_i   (dst_ext[k]),
        .out_valid_o (chain_valid[k+1]),
        .out_ready_i (chain_ready[k+1]),
        .src_acc_o   (chain_src[k+1]),
        .dst_acc_o   (chain_dst[k+1]),
        .src_pos_o   (),
        .dst_pos_o   (),
        .last_o      (chain_last[k+1])
      );
    end
  end

  // Drive the result stream from the last cell
  assign m_axis_tvalid            = chain_valid[NUM_AXES];
  assign chain_ready[NUM_AXES]    = m_axis_tready;
  assign m_axis_tdata             = {chain_dst[NUM_AXES], chain_src[NUM_AXES]};
  assign m_axis_tlast             = chain_last[NUM_AXES];

endmodule
`default_nettype wire

### tb/sv/tpag_address_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tensor permute address checker
// Watches the register, request and address pair channels of the address
// generator, predicts each address pair from its own copy of the odometer
// and the registers, and compares every pair the sink accepts, in order.
// ----------------------------------------------------------------------------
module tpag_address_checker
  import tpag_pkg::*;
#(
  parameter int unsigned MAX_EXTENT = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  req_valid_i,
  input  logic                  req_ready_i,
  input  logic [7:0]            req_data_i,   // [0] restart, [7:1] zero
  input  logic                  pair_valid_i,
  input  logic                  pair_ready_i,
  input  logic [2*OFFSET_W-1:0] pair_data_i,  // [23:0] source_offset,
                                              // [47:24] dest_offset
  input  logic                  pair_last_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  localparam int unsigned MAX_REPORTS = 40;

  typedef int unsigned axis_vec_t [NUM_AXES];

  typedef struct packed {
    logic [OFFSET_W-1:0] source_offset;
    logic [OFFSET_W-1:0] dest_offset;
    logic                last;
  } addr_pair_t;

  logic [EXTENT_W-1:0] extent_q [NUM_AXES];
  logic [ORDER_W-1:0]  axis_order_q;
  axis_vec_t           coord_q;
  addr_pair_t          pending_pairs [$];

  // Map a raw extent register onto the size the walk really uses
  function automatic int unsigned effective_extent(logic [EXTENT_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > MAX_EXTENT) return MAX_EXTENT;
    return raw;
  endfunction

  // Row-major offset, innermost axis last; only the low OFFSET_W bits count
  function automatic logic [OFFSET_W-1:0] linear_offset(axis_vec_t ext, axis_vec_t pos);
    longint unsigned stride;
    longint unsigned offset;
    stride = 1;
    offset = 0;
    for (int i = NUM_AXES - 1; i >= 0; i--) begin
      offset = offset + longint'(pos[i]) * stride;
      stride = stride * ext[i];
    end
    return OFFSET_W'(offset);
  endfunction

  // Address pair for the current element, then advance the odometer
  function automatic addr_pair_t next_address_pair(logic restart);
    axis_vec_t             ext;
    axis_vec_t             dst_ext;
    axis_vec_t             dst_pos;
    logic [AXIS_SEL_W-1:0] src_axis;
    addr_pair_t            pair;
    bit                    carry;
    if (restart) begin
      foreach (coord_q[i]) coord_q[i] = 0;
    end
    for (int i = 0; i < NUM_AXES; i++) ext[i] = effective_extent(extent_q[i]);
    for (int i = 0; i < NUM_AXES; i++) begin
      src_axis   = axis_order_q[AXIS_SEL_W*i +: AXIS_SEL_W];
      dst_ext[i] = ext[src_axis];
      dst_pos[i] = coord_q[src_axis];
    end
    pair.source_offset = linear_offset(ext, coord_q);
    pair.dest_offset   = linear_offset(dst_ext, dst_pos);
    // a digit at or past its last index rolls over and carries on
    carry = 1'b1;
    for (int i = NUM_AXES - 1; i >= 0; i--) begin
      if (carry) begin
        if (coord_q[i] + 1 < ext[i]) begin
          coord_q[i] = coord_q[i] + 1;
          carry      = 1'b0;
        end else begin
          coord_q[i] = 0;
        end
      end
    end
    pair.last = carry;
    return pair;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    addr_pair_t expected;
    bit         mismatch;
    if (!rst_ni) begin
      foreach (extent_q[i]) extent_q[i] = EXTENT_RESET;
      foreach (coord_q[i]) coord_q[i] = 0;
      axis_order_q = AXIS_ORDER_RESET;
      pending_pairs.delete();
      pending_o = 0;
    end else begin
      // compare an accepted pair against the oldest prediction
      if (pair_valid_i && pair_ready_i) begin
        if (pending_pairs.size() == 0) begin
          if (fail_count_o < MAX_REPORTS)
            $display("%0t: unexpected pair: expected none, actual src=%0d dst=%0d last=%0b",
                     $realtime, pair_data_i[OFFSET_W-1:0],
                     pair_data_i[2*OFFSET_W-1:OFFSET_W], pair_last_i);
          fail_count_o++;
        end else begin
          expected = pending_pairs.pop_front();
          mismatch = 1'b0;
          if (pair_data_i[OFFSET_W-1:0] !== expected.source_offset) begin
            mismatch = 1'b1;
            if (fail_count_o < MAX_REPORTS)
              $display("%0t: source_offset: expected %0d, actual %0d", $realtime,
                       expected.source_offset, pair_data_i[OFFSET_W-1:0]);
          end
          if (pair_data_i[2*OFFSET_W-1:OFFSET_W] !== expected.dest_offset) begin
            mismatch = 1'b1;
            if (fail_count_o < MAX_REPORTS)
              $display("%0t: dest_offset: expected %0d, actual %0d", $realtime,
                       expected.dest_offset, pair_data_i[2*OFFSET_W-1:OFFSET_W]);
          end
          if (pair_last_i !== expected.last) begin
            mismatch = 1'b1;
            if (fail_count_o < MAX_REPORTS)
              $display("%0t: last: expected %0b, actual %0b", $realtime,
                       expected.last, pair_last_i);
          end
          if (mismatch) fail_count_o++;
        end
      end

      // track register writes; unknown indexes are dropped
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_EXTENT_0, REG_EXTENT_1, REG_EXTENT_2, REG_EXTENT_3: begin
            extent_q[cfg_index_i] = cfg_data_i[EXTENT_W-1:0];
          end
          REG_AXIS_ORDER: begin
            axis_order_q = cfg_data_i[ORDER_W-1:0];
          end
          default: begin
          end
        endcase
      end

      // predict the pair for each accepted request
      if (req_valid_i && req_ready_i)
        pending_pairs.insert(pending_pairs.size(), next_address_pair(req_data_i[0]));

      pending_o = pending_pairs.size();
    end
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tensor permute address generator testbench
// Drives register writes and request transactions with random idling and
// back-pressure, runs directed shapes first and then random walks, and lets
// the address checker judge every address pair.
// ----------------------------------------------------------------------------
module tb;
  import tpag_pkg::*;

  localparam int unsigned MAX_EXT       = 64;
  localparam int unsigned RANDOM_ITEMS  = 1300;
  localparam int unsigned CALM_ITEMS    = 200;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned HOLD_PHASE    = 3;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT   = 20000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  req_valid  = 1'b0;
  logic [7:0]            req_data   = '0;
  logic                  pair_ready = 1'b0;
  logic                  cfg_ready;
  logic                  req_ready;
  logic                  pair_valid;
  logic [2*OFFSET_W-1:0] pair_data;
  logic                  pair_last;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent    = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_done    = 0;
  int unsigned hold_left     = 0;
  int unsigned stall_left    = 0;
  bit          tx_idle_en    = 1'b0;
  bit          rx_idle_en    = 1'b0;

  always #6 clk = ~clk;

  tensor_permute_address_generator #(
    .MAX_EXTENT(MAX_EXT)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(req_valid),
    .s_axis_tready(req_ready),
    .s_axis_tdata (req_data),
    .m_axis_tvalid(pair_valid),
    .m_axis_tready(pair_ready),
    .m_axis_tdata (pair_data),
    .m_axis_tlast (pair_last)
  );

  tpag_address_checker #(
    .MAX_EXTENT(MAX_EXT)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .req_valid_i (req_valid),
    .req_ready_i (req_ready),
    .req_data_i  (req_data),
    .pair_valid_i(pair_valid),
    .pair_ready_i(pair_ready),
    .pair_data_i (pair_data),
    .pair_last_i (pair_last),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Sink ready: long hold on request, otherwise random stall bursts
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      pair_ready <= 1'b0;
    end else if (holds_done != hold_requests) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      pair_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pair_ready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 8);
      pair_ready <= 1'b0;
    end else begin
      pair_ready <= 1'b1;
    end
  end

  // Drop valid and idle the request side
  task automatic pause_sender(int unsigned cycles);
    req_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Offer one request and hold it until the transaction completes
  task automatic send_request(bit restart);
    if (tx_idle_en && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 9));
    req_valid <= 1'b1;
    req_data  <= {7'b0, restart};
    do begin
      @(posedge clk);
    end while (!req_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Hold requests until every predicted pair is back and the pipe is empty
  task automatic wait_walk_drained();
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_shape(logic [7:0] e0, e1, e2, e3, order);
    write_reg(REG_EXTENT_0, e0);
    write_reg(REG_EXTENT_1, e1);
    write_reg(REG_EXTENT_2, e2);
    write_reg(REG_EXTENT_3, e3);
    write_reg(REG_AXIS_ORDER, order);
  endtask

  // Walk count elements; restarts are rare after the first request
  task automatic run_walk(int unsigned count, bit first_restart);
    send_request(first_restart);
    repeat (count - 1) send_request($urandom_range(0, 29) == 0);
  endtask

  // Mostly small extents so walks wrap; zero and oversized values now and then
  function automatic logic [CFG_DATA_W-1:0] pick_extent();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) return '0;
    if (roll < 12) return CFG_DATA_W'($urandom_range(65, 255));
    if (roll < 22) return CFG_DATA_W'($urandom_range(6, MAX_EXT));
    return CFG_DATA_W'($urandom_range(1, 5));
  endfunction

  // Mostly a true permutation; sometimes any byte, repeated axes included
  function automatic logic [CFG_DATA_W-1:0] pick_axis_order();
    logic [AXIS_SEL_W-1:0] axes [NUM_AXES];
    logic [AXIS_SEL_W-1:0] swap;
    logic [ORDER_W-1:0]    order;
    int unsigned           j;
    if ($urandom_range(0, 7) == 0) return CFG_DATA_W'($urandom);
    for (int i = 0; i < NUM_AXES; i++) axes[i] = AXIS_SEL_W'(i);
    for (int i = NUM_AXES - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      swap    = axes[i];
      axes[i] = axes[j];
      axes[j] = swap;
    end
    for (int i = 0; i < NUM_AXES; i++) order[AXIS_SEL_W*i +: AXIS_SEL_W] = axes[i];
    return order;
  endfunction

  initial begin
    int unsigned phase;
    int unsigned target;
    int unsigned waited;
    bit          calm;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    // reset shape: a single element, every pair is the last one
    send_request(1'b0);
    send_request(1'b1);
    wait_walk_drained();

    // reversed axes, an extent of zero acting as one
    program_shape(8'd0, 8'd3, 8'd2, 8'd4, 8'h1B);
    run_walk(6, 1'b1);
    wait_walk_drained();

    // clamped extents and all destination axes taken from axis 0
    program_shape(8'd127, 8'hC8, 8'd65, 8'd64, 8'h00);
    for (int k = REG_AXIS_ORDER + 1; k < 2**CFG_IDX_W; k++)
      write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
    run_walk(5, 1'b1);
    wait_walk_drained();

    // shrink the shape mid-walk so coordinates sit past their last index
    program_shape(8'd1, 8'd1, 8'd4, 8'd4, 8'hE4);
    run_walk(7, 1'b1);
    wait_walk_drained();
    program_shape(8'd2, 8'd1, 8'd1, 8'd2, 8'h4E);
    run_walk(5, 1'b0);

    // random shapes and walks
    target = items_sent + RANDOM_ITEMS;
    phase  = 0;
    while (items_sent < target) begin
      wait_walk_drained();
      calm       = items_sent + CALM_ITEMS >= target;
      tx_idle_en = !calm && $urandom_range(0, 3) != 0;
      rx_idle_en = !calm && $urandom_range(0, 3) != 0;
      if (phase == 0 || $urandom_range(0, 2) != 0) write_reg(REG_EXTENT_0, pick_extent());
      if (phase == 0 || $urandom_range(0, 2) != 0) write_reg(REG_EXTENT_1, pick_extent());
      if (phase == 0 || $urandom_range(0, 2) != 0) write_reg(REG_EXTENT_2, pick_extent());
      if (phase == 0 || $urandom_range(0, 2) != 0) write_reg(REG_EXTENT_3, pick_extent());
      if (phase == 0 || $urandom_range(0, 2) != 0) write_reg(REG_AXIS_ORDER, pick_axis_order());
      if ($urandom_range(0, 9) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_AXIS_ORDER + 1, 2**CFG_IDX_W - 1)),
                  CFG_DATA_W'($urandom));
      // back up the result side while requests keep coming
      if (phase == HOLD_PHASE) begin
        hold_requests++;
        run_walk(60, 1'b1);
      end else begin
        run_walk($urandom_range(10, 60), $urandom_range(0, 3) != 0);
      end
      phase++;
    end

    // let the last pairs come back
    req_valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (16) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
